[src/dsa_pkg.sv]
// Shared types and constants of the descriptor slot allocator.
package dsa_pkg;

  localparam int MAX_SLOTS    = 64;
  localparam int IDX_W        = $clog2(MAX_SLOTS);
  localparam int CNT_W        = IDX_W + 1;
  localparam int ADDR_W       = 64;
  localparam int INC_W        = 16;
  localparam int SLOT_COUNT_W = 7;
  localparam int STATUS_W     = 3;
  localparam int MODE_W       = 2;
  localparam int CFG_INDEX_W  = 2;
  localparam int PROD_W       = IDX_W + INC_W;
  localparam int DIV_BITS     = 8;
  localparam int DIV_STEPS    = ADDR_W / DIV_BITS;
  localparam int DIV_CNT_W    = $clog2(DIV_STEPS);

  localparam logic [INC_W-1:0]        INC_RESET        = INC_W'(32);
  localparam logic [SLOT_COUNT_W-1:0] SLOT_COUNT_RESET = SLOT_COUNT_W'(64);

  localparam logic [CFG_INDEX_W-1:0] CFG_CPU_BASE   = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] CFG_GPU_BASE   = CFG_INDEX_W'(1);
  localparam logic [CFG_INDEX_W-1:0] CFG_INCREMENT  = CFG_INDEX_W'(2);
  localparam logic [CFG_INDEX_W-1:0] CFG_SLOT_COUNT = CFG_INDEX_W'(3);

  localparam logic [MODE_W-1:0] MODE_ALLOC  = MODE_W'(0);
  localparam logic [MODE_W-1:0] MODE_FREE   = MODE_W'(1);
  localparam logic [MODE_W-1:0] MODE_REINIT = MODE_W'(2);

  localparam logic [STATUS_W-1:0] ST_OK       = STATUS_W'(0);
  localparam logic [STATUS_W-1:0] ST_EMPTY    = STATUS_W'(1);
  localparam logic [STATUS_W-1:0] ST_MISMATCH = STATUS_W'(2);
  localparam logic [STATUS_W-1:0] ST_RANGE    = STATUS_W'(3);
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = STATUS_W'(4);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_RD,
    S_MUL,
    S_ADD,
    S_DIV,
    S_CHECK,
    S_OUT
  } state_t;

  typedef struct packed {
    logic                capture;
    logic                pop;
    logic                take_fresh;
    logic                load_slot;
    logic                mul;
    logic                add;
    logic                div_step;
    logic                push;
    logic                reinit;
    logic                res_err;
    logic [STATUS_W-1:0] res_code;
    logic                res_free;
    logic                load_out;
  } dsa_cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              stack_nonempty;
    logic              fresh_avail;
    logic              inc_zero;
    logic              div_last;
    logic              quot_mismatch;
    logic              quot_range;
    logic              overflow;
    logic              out_free;
  } dsa_sts_t;

endpackage

[src/dsa_ctrl.sv]
// Sequencer of the descriptor slot allocator.
module dsa_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  dsa_pkg::dsa_sts_t sts,
  output dsa_pkg::dsa_cmd_t cmd
);

  dsa_pkg::state_t state;
  dsa_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dsa_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != dsa_pkg::S_IDLE);

  always_comb begin
    state_next = state;
    case (state)
      dsa_pkg::S_IDLE: begin
        if (in_valid) state_next = dsa_pkg::S_DECODE;
      end
      dsa_pkg::S_DECODE: begin
        case (sts.mode)
          dsa_pkg::MODE_ALLOC: begin
            if (sts.stack_nonempty) state_next = dsa_pkg::S_RD;
            else if (sts.fresh_avail) state_next = dsa_pkg::S_MUL;
            else state_next = dsa_pkg::S_OUT;
          end
          dsa_pkg::MODE_FREE: begin
            state_next = sts.inc_zero ? dsa_pkg::S_OUT : dsa_pkg::S_DIV;
          end
          default: state_next = dsa_pkg::S_OUT;
        endcase
      end
      dsa_pkg::S_RD:    state_next = dsa_pkg::S_MUL;
      dsa_pkg::S_MUL:   state_next = dsa_pkg::S_ADD;
      dsa_pkg::S_ADD:   state_next = dsa_pkg::S_OUT;
      dsa_pkg::S_DIV: begin
        if (sts.div_last) state_next = dsa_pkg::S_CHECK;
      end
      dsa_pkg::S_CHECK: state_next = dsa_pkg::S_OUT;
      dsa_pkg::S_OUT: begin
        if (sts.out_free) state_next = dsa_pkg::S_IDLE;
      end
      default: state_next = dsa_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.res_code = dsa_pkg::ST_OK;
    case (state)
      dsa_pkg::S_IDLE: begin
        cmd.capture = in_valid;
      end
      dsa_pkg::S_DECODE: begin
        case (sts.mode)
          dsa_pkg::MODE_ALLOC: begin
            if (sts.stack_nonempty) begin
              cmd.pop = 1'b1;
            end else if (sts.fresh_avail) begin
              cmd.take_fresh = 1'b1;
            end else begin
              cmd.res_err  = 1'b1;
              cmd.res_code = dsa_pkg::ST_EMPTY;
            end
          end
          dsa_pkg::MODE_FREE: begin
            if (sts.inc_zero) begin
              cmd.res_err  = 1'b1;
              cmd.res_code = dsa_pkg::ST_RANGE;
            end
          end
          dsa_pkg::MODE_REINIT: begin
            cmd.reinit  = 1'b1;
            cmd.res_err = 1'b1;
          end
          default: begin
            cmd.res_err = 1'b1;
          end
        endcase
      end
      dsa_pkg::S_RD:  cmd.load_slot = 1'b1;
      dsa_pkg::S_MUL: cmd.mul = 1'b1;
      dsa_pkg::S_ADD: cmd.add = 1'b1;
      dsa_pkg::S_DIV: cmd.div_step = 1'b1;
      dsa_pkg::S_CHECK: begin
        if (sts.quot_mismatch) begin
          cmd.res_err  = 1'b1;
          cmd.res_code = dsa_pkg::ST_MISMATCH;
        end else if (sts.quot_range) begin
          cmd.res_err  = 1'b1;
          cmd.res_code = dsa_pkg::ST_RANGE;
        end else if (sts.overflow) begin
          cmd.res_err  = 1'b1;
          cmd.res_code = dsa_pkg::ST_OVERFLOW;
        end else begin
          cmd.push     = 1'b1;
          cmd.res_free = 1'b1;
        end
      end
      dsa_pkg::S_OUT: cmd.load_out = sts.out_free;
      default: ;
    endcase
  end

endmodule

[src/dsa_dpath.sv]
// Datapath: config registers, slot counters, freed-slot stack, divider, handle math.
module dsa_dpath (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [dsa_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [dsa_pkg::ADDR_W-1:0]        cfg_data,
  input  logic [dsa_pkg::MODE_W-1:0]        mode,
  input  logic [dsa_pkg::ADDR_W-1:0]        cpu_address,
  input  logic [dsa_pkg::ADDR_W-1:0]        gpu_address,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [dsa_pkg::STATUS_W-1:0]      status,
  output logic [dsa_pkg::IDX_W-1:0]         slot_index,
  output logic [dsa_pkg::ADDR_W-1:0]        cpu_handle,
  output logic [dsa_pkg::ADDR_W-1:0]        gpu_handle,
  input  dsa_pkg::dsa_cmd_t                 cmd,
  output dsa_pkg::dsa_sts_t                 sts
);

  logic [dsa_pkg::ADDR_W-1:0]       cpu_base;
  logic [dsa_pkg::ADDR_W-1:0]       gpu_base;
  logic [dsa_pkg::INC_W-1:0]        handle_increment;
  logic [dsa_pkg::SLOT_COUNT_W-1:0] slot_count;

  logic [dsa_pkg::CNT_W-1:0]        freed_count;
  logic [dsa_pkg::CNT_W-1:0]        fresh_next;
  logic [dsa_pkg::IDX_W-1:0]        freed_stack [dsa_pkg::MAX_SLOTS];
  logic [dsa_pkg::IDX_W-1:0]        rd_data;
  logic [dsa_pkg::IDX_W-1:0]        pop_addr;

  logic [dsa_pkg::MODE_W-1:0]       mode_q;
  logic [dsa_pkg::ADDR_W-1:0]       dq_c;
  logic [dsa_pkg::ADDR_W-1:0]       dq_g;
  logic [dsa_pkg::INC_W-1:0]        rem_c;
  logic [dsa_pkg::INC_W-1:0]        rem_g;
  logic [dsa_pkg::DIV_CNT_W-1:0]    div_cnt;
  logic [dsa_pkg::INC_W+dsa_pkg::DIV_BITS-1:0] step_c;
  logic [dsa_pkg::INC_W+dsa_pkg::DIV_BITS-1:0] step_g;

  logic [dsa_pkg::IDX_W-1:0]        slot;
  logic [dsa_pkg::PROD_W-1:0]       prod;
  logic [dsa_pkg::SLOT_COUNT_W-1:0] pool;

  logic [dsa_pkg::STATUS_W-1:0]     res_status;
  logic [dsa_pkg::IDX_W-1:0]        res_idx;
  logic [dsa_pkg::ADDR_W-1:0]       res_cpu;
  logic [dsa_pkg::ADDR_W-1:0]       res_gpu;

  // restoring division, DIV_BITS quotient bits per call
  function automatic logic [dsa_pkg::INC_W+dsa_pkg::DIV_BITS-1:0] div_chunk(
    input logic [dsa_pkg::INC_W-1:0]    rem,
    input logic [dsa_pkg::DIV_BITS-1:0] bits,
    input logic [dsa_pkg::INC_W-1:0]    d
  );
    logic [dsa_pkg::INC_W:0]      r;
    logic [dsa_pkg::DIV_BITS-1:0] q;
    r = {1'b0, rem};
    q = '0;
    for (int i = dsa_pkg::DIV_BITS - 1; i >= 0; i--) begin
      r = {r[dsa_pkg::INC_W-1:0], bits[i]};
      if (r >= {1'b0, d}) begin
        r    = r - {1'b0, d};
        q[i] = 1'b1;
      end
    end
    return {r[dsa_pkg::INC_W-1:0], q};
  endfunction

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cpu_base         <= '0;
      gpu_base         <= '0;
      handle_increment <= dsa_pkg::INC_RESET;
      slot_count       <= dsa_pkg::SLOT_COUNT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        dsa_pkg::CFG_CPU_BASE:   cpu_base <= cfg_data;
        dsa_pkg::CFG_GPU_BASE:   gpu_base <= cfg_data;
        dsa_pkg::CFG_INCREMENT:  handle_increment <= cfg_data[dsa_pkg::INC_W-1:0];
        dsa_pkg::CFG_SLOT_COUNT: slot_count <= cfg_data[dsa_pkg::SLOT_COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign pool = (slot_count > dsa_pkg::SLOT_COUNT_W'(dsa_pkg::MAX_SLOTS)) ?
                dsa_pkg::SLOT_COUNT_W'(dsa_pkg::MAX_SLOTS) : slot_count;

  // counters
  always_ff @(posedge clk) begin
    if (rst) begin
      freed_count <= '0;
      fresh_next  <= '0;
    end else if (cmd.reinit) begin
      freed_count <= '0;
      fresh_next  <= '0;
    end else begin
      if (cmd.pop)        freed_count <= freed_count - 1'b1;
      if (cmd.push)       freed_count <= freed_count + 1'b1;
      if (cmd.take_fresh) fresh_next  <= fresh_next + 1'b1;
    end
  end

  // freed-slot stack
  assign pop_addr = dsa_pkg::IDX_W'(freed_count - 1'b1);

  always_ff @(posedge clk) begin
    if (cmd.push) freed_stack[freed_count[dsa_pkg::IDX_W-1:0]] <= dq_c[dsa_pkg::IDX_W-1:0];
    if (cmd.pop)  rd_data <= freed_stack[pop_addr];
  end

  // request capture and divider
  assign step_c = div_chunk(rem_c, dq_c[dsa_pkg::ADDR_W-1 -: dsa_pkg::DIV_BITS],
                            handle_increment);
  assign step_g = div_chunk(rem_g, dq_g[dsa_pkg::ADDR_W-1 -: dsa_pkg::DIV_BITS],
                            handle_increment);

  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (cmd.capture) begin
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      div_cnt <= div_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_q <= mode;
      dq_c   <= cpu_address - cpu_base;
      dq_g   <= gpu_address - gpu_base;
      rem_c  <= '0;
      rem_g  <= '0;
    end else if (cmd.div_step) begin
      dq_c  <= {dq_c[dsa_pkg::ADDR_W-dsa_pkg::DIV_BITS-1:0], step_c[dsa_pkg::DIV_BITS-1:0]};
      dq_g  <= {dq_g[dsa_pkg::ADDR_W-dsa_pkg::DIV_BITS-1:0], step_g[dsa_pkg::DIV_BITS-1:0]};
      rem_c <= step_c[dsa_pkg::INC_W+dsa_pkg::DIV_BITS-1:dsa_pkg::DIV_BITS];
      rem_g <= step_g[dsa_pkg::INC_W+dsa_pkg::DIV_BITS-1:dsa_pkg::DIV_BITS];
    end
  end

  // handle math: slot * increment, then base add
  always_ff @(posedge clk) begin
    if (cmd.take_fresh) slot <= fresh_next[dsa_pkg::IDX_W-1:0];
    if (cmd.load_slot)  slot <= rd_data;
    if (cmd.mul) prod <= dsa_pkg::PROD_W'(slot) * dsa_pkg::PROD_W'(handle_increment);
  end

  // result
  always_ff @(posedge clk) begin
    if (cmd.res_err) begin
      res_status <= cmd.res_code;
      res_idx    <= '0;
      res_cpu    <= '0;
      res_gpu    <= '0;
    end else if (cmd.res_free) begin
      res_status <= dsa_pkg::ST_OK;
      res_idx    <= dq_c[dsa_pkg::IDX_W-1:0];
      res_cpu    <= '0;
      res_gpu    <= '0;
    end else if (cmd.add) begin
      res_status <= dsa_pkg::ST_OK;
      res_idx    <= slot;
      res_cpu    <= cpu_base + dsa_pkg::ADDR_W'(prod);
      res_gpu    <= gpu_base + dsa_pkg::ADDR_W'(prod);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      status     <= res_status;
      slot_index <= res_idx;
      cpu_handle <= res_cpu;
      gpu_handle <= res_gpu;
    end
  end

  always_comb begin
    sts                = '0;
    sts.mode           = mode_q;
    sts.stack_nonempty = (freed_count != '0);
    sts.fresh_avail    = (dsa_pkg::SLOT_COUNT_W'(fresh_next) < pool);
    sts.inc_zero       = (handle_increment == '0);
    sts.div_last       = (div_cnt == dsa_pkg::DIV_CNT_W'(dsa_pkg::DIV_STEPS - 1));
    sts.quot_mismatch  = (dq_c != dq_g);
    sts.quot_range     = (|dq_c[dsa_pkg::ADDR_W-1:dsa_pkg::CNT_W]) ||
                         (dsa_pkg::SLOT_COUNT_W'(dq_c[dsa_pkg::CNT_W-1:0]) >= pool);
    sts.overflow       = (freed_count >= fresh_next) ||
                         (freed_count >= dsa_pkg::CNT_W'(dsa_pkg::MAX_SLOTS));
    sts.out_free       = !out_valid || !out_stall;
  end

  a_freed_le_fresh: assert property (@(posedge clk) disable iff (rst)
    freed_count <= fresh_next)
    else $error("freed count exceeds handed-out slots");

  a_fresh_bound: assert property (@(posedge clk) disable iff (rst)
    fresh_next <= dsa_pkg::CNT_W'(dsa_pkg::MAX_SLOTS))
    else $error("fresh counter past pool depth");

  a_push_pop: assert property (@(posedge clk) disable iff (rst)
    !(cmd.push && cmd.pop))
    else $error("stack push and pop in one cycle");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || !out_stall))
    else $error("output register overwritten while held");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |=> freed_count == $past(freed_count) - 1'b1)
    else $error("pop did not retire one stack entry");

endmodule

[src/descriptor_slot_allocator.sv]
// Top level of the descriptor slot allocator.
// LIFO slot allocator: one result beat per request beat. An allocate takes a
// fresh slot, or a slot from the freed stack by a memory read, then does the
// multiply and the base add; a free runs the divider that recovers the
// index from each handle at 8 quotient bits per cycle over 64 bits; a reinit,
// an unused mode, an allocate with no slot left or a free with a zero stride
// goes straight to the result. One request is in work at a time; the output
// register lets the next request enter while a result waits to be taken.
// The config port is always ready; write it only while the block is idle.
module descriptor_slot_allocator (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [dsa_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [dsa_pkg::ADDR_W-1:0]      cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [dsa_pkg::MODE_W-1:0]      mode,
  input  logic [dsa_pkg::ADDR_W-1:0]      cpu_address,
  input  logic [dsa_pkg::ADDR_W-1:0]      gpu_address,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [dsa_pkg::STATUS_W-1:0]    status,
  output logic [dsa_pkg::IDX_W-1:0]       slot_index,
  output logic [dsa_pkg::ADDR_W-1:0]      cpu_handle,
  output logic [dsa_pkg::ADDR_W-1:0]      gpu_handle
);

  dsa_pkg::dsa_cmd_t cmd;
  dsa_pkg::dsa_sts_t sts;

  dsa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  dsa_dpath u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mode        (mode),
    .cpu_address (cpu_address),
    .gpu_address (gpu_address),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .slot_index  (slot_index),
    .cpu_handle  (cpu_handle),
    .gpu_handle  (gpu_handle),
    .cmd         (cmd),
    .sts         (sts)
  );

endmodule

[tb/descriptor_slot_allocator_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench of the descriptor slot allocator: directed script, then random phases.
module descriptor_slot_allocator_tb;

  localparam logic [dsa_pkg::MODE_W-1:0] MODE_UNUSED = dsa_pkg::MODE_W'(3);
  localparam int PHASES     = 8;
  localparam int PHASE_REQS = 250;

  typedef struct packed {
    logic [dsa_pkg::STATUS_W-1:0] status;
    logic [dsa_pkg::IDX_W-1:0]    slot;
    logic [dsa_pkg::ADDR_W-1:0]   cpu_h;
    logic [dsa_pkg::ADDR_W-1:0]   gpu_h;
  } slot_result_t;

  typedef struct {
    bit                              is_write;
    logic [dsa_pkg::CFG_INDEX_W-1:0] sel;
    logic [dsa_pkg::MODE_W-1:0]      req_mode;
    logic [dsa_pkg::ADDR_W-1:0]      a;
    logic [dsa_pkg::ADDR_W-1:0]      b;
    bit                              fixed;
    slot_result_t                    want;
  } script_row_t;

  logic                            clk = 1'b0;
  logic                            rst;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [dsa_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [dsa_pkg::ADDR_W-1:0]      cfg_data;
  logic                            in_valid;
  logic                            in_stall;
  logic [dsa_pkg::MODE_W-1:0]      mode;
  logic [dsa_pkg::ADDR_W-1:0]      cpu_address;
  logic [dsa_pkg::ADDR_W-1:0]      gpu_address;
  logic                            out_valid;
  logic                            out_stall;
  logic [dsa_pkg::STATUS_W-1:0]    status;
  logic [dsa_pkg::IDX_W-1:0]       slot_index;
  logic [dsa_pkg::ADDR_W-1:0]      cpu_handle;
  logic [dsa_pkg::ADDR_W-1:0]      gpu_handle;

  // predicted state and config
  logic [dsa_pkg::ADDR_W-1:0]       base_cpu;
  logic [dsa_pkg::ADDR_W-1:0]       base_gpu;
  logic [dsa_pkg::INC_W-1:0]        stride;
  logic [dsa_pkg::SLOT_COUNT_W-1:0] slots_cfg;
  logic [dsa_pkg::IDX_W-1:0]        freed_slots [dsa_pkg::MAX_SLOTS];
  int unsigned                      freed_depth;
  int unsigned                      fresh_idx;

  slot_result_t expected_q[$];
  script_row_t  script[$];
  int           live_slots[$];
  int           err_count = 0;
  bit           calm = 1'b0;
  int           hold_len = 0;

  descriptor_slot_allocator dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .mode        (mode),
    .cpu_address (cpu_address),
    .gpu_address (gpu_address),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .slot_index  (slot_index),
    .cpu_handle  (cpu_handle),
    .gpu_handle  (gpu_handle)
  );

  always #2 clk = ~clk;

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    if (err_count < 50) $display("mismatch at %0t: %s", $realtime, msg);
    err_count++;
  endtask

  function automatic slot_result_t model_request(input logic [dsa_pkg::MODE_W-1:0] m,
                                                 input logic [dsa_pkg::ADDR_W-1:0] ca,
                                                 input logic [dsa_pkg::ADDR_W-1:0] ga);
    slot_result_t r;
    logic [dsa_pkg::ADDR_W-1:0] ci;
    logic [dsa_pkg::ADDR_W-1:0] gi;
    int unsigned lim;
    bit granted;
    r = '0;
    granted = 1'b0;
    lim = (slots_cfg > dsa_pkg::MAX_SLOTS) ? dsa_pkg::MAX_SLOTS : slots_cfg;
    case (m)
      dsa_pkg::MODE_ALLOC: begin
        if (freed_depth > 0 && freed_depth <= dsa_pkg::MAX_SLOTS) begin
          freed_depth--;
          r.slot = freed_slots[freed_depth];
          granted = 1'b1;
        end else if (fresh_idx < lim) begin
          r.slot = fresh_idx[dsa_pkg::IDX_W-1:0];
          fresh_idx++;
          granted = 1'b1;
        end else begin
          r.status = dsa_pkg::ST_EMPTY;
        end
        if (granted) begin
          r.cpu_h = base_cpu + dsa_pkg::ADDR_W'(r.slot) * dsa_pkg::ADDR_W'(stride);
          r.gpu_h = base_gpu + dsa_pkg::ADDR_W'(r.slot) * dsa_pkg::ADDR_W'(stride);
        end
      end
      dsa_pkg::MODE_FREE: begin
        if (stride == '0) begin
          r.status = dsa_pkg::ST_RANGE;
        end else begin
          ci = (ca - base_cpu) / dsa_pkg::ADDR_W'(stride);
          gi = (ga - base_gpu) / dsa_pkg::ADDR_W'(stride);
          if (ci != gi) r.status = dsa_pkg::ST_MISMATCH;
          else if (ci >= dsa_pkg::ADDR_W'(lim)) r.status = dsa_pkg::ST_RANGE;
          else if (freed_depth >= fresh_idx || freed_depth >= dsa_pkg::MAX_SLOTS)
            r.status = dsa_pkg::ST_OVERFLOW;
          else begin
            freed_slots[freed_depth] = ci[dsa_pkg::IDX_W-1:0];
            freed_depth++;
            r.slot = ci[dsa_pkg::IDX_W-1:0];
          end
        end
      end
      dsa_pkg::MODE_REINIT: begin
        freed_depth = 0;
        fresh_idx = 0;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic void add_req(input logic [dsa_pkg::MODE_W-1:0] m,
                                  input logic [dsa_pkg::ADDR_W-1:0] a,
                                  input logic [dsa_pkg::ADDR_W-1:0] b);
    script_row_t row;
    row.is_write = 1'b0;
    row.sel = dsa_pkg::CFG_CPU_BASE;
    row.req_mode = m;
    row.a = a;
    row.b = b;
    row.fixed = 1'b0;
    row.want = '0;
    script.insert(script.size(), row);
  endfunction

  function automatic void add_chk(input logic [dsa_pkg::MODE_W-1:0] m,
                                  input logic [dsa_pkg::ADDR_W-1:0] a,
                                  input logic [dsa_pkg::ADDR_W-1:0] b,
                                  input logic [dsa_pkg::STATUS_W-1:0] st,
                                  input logic [dsa_pkg::IDX_W-1:0] idx,
                                  input logic [dsa_pkg::ADDR_W-1:0] ch,
                                  input logic [dsa_pkg::ADDR_W-1:0] gh);
    add_req(m, a, b);
    script[$].fixed = 1'b1;
    script[$].want = '{st, idx, ch, gh};
  endfunction

  function automatic void add_write(input logic [dsa_pkg::CFG_INDEX_W-1:0] sel,
                                    input logic [dsa_pkg::ADDR_W-1:0] d);
    add_req(dsa_pkg::MODE_ALLOC, d, '0);
    script[$].is_write = 1'b1;
    script[$].sel = sel;
  endfunction

  // called at a falling edge; returns at a falling edge with nothing assigned there
  task automatic issue(input logic [dsa_pkg::MODE_W-1:0] m,
                       input logic [dsa_pkg::ADDR_W-1:0] ca,
                       input logic [dsa_pkg::ADDR_W-1:0] ga, input bit fixed,
                       input slot_result_t want);
    slot_result_t pred;
    int hits[$];
    in_valid    <= 1'b1;
    mode        <= m;
    cpu_address <= ca;
    gpu_address <= ga;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred = model_request(m, ca, ga);
    if (pred.status == dsa_pkg::ST_OK) begin
      if (m == dsa_pkg::MODE_ALLOC) live_slots.insert(live_slots.size(), pred.slot);
      else if (m == dsa_pkg::MODE_FREE) begin
        hits = live_slots.find_first_index(x) with (x == pred.slot);
        if (hits.size() != 0) live_slots.delete(hits[0]);
      end else if (m == dsa_pkg::MODE_REINIT) live_slots.delete();
    end
    expected_q.insert(expected_q.size(), fixed ? want : pred);
    @(negedge clk);
  endtask

  task automatic pause();
    while (!calm && $urandom_range(0, 99) < 31) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_reg(input logic [dsa_pkg::CFG_INDEX_W-1:0] sel,
                           input logic [dsa_pkg::ADDR_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (sel)
      dsa_pkg::CFG_CPU_BASE:   base_cpu  = d;
      dsa_pkg::CFG_GPU_BASE:   base_gpu  = d;
      dsa_pkg::CFG_INCREMENT:  stride    = d[dsa_pkg::INC_W-1:0];
      dsa_pkg::CFG_SLOT_COUNT: slots_cfg = d[dsa_pkg::SLOT_COUNT_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // receiver side: random stalls, a calm phase, and one long hold-off
  initial begin
    int n;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_len > 0) begin
        n = hold_len;
        hold_len = 0;
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
      end else begin
        out_stall <= !calm && ($urandom_range(0, 99) < 31);
      end
    end
  end

  always @(posedge clk) begin : result_check
    slot_result_t e;
    if (!rst && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        report_mismatch("result beat with nothing pending");
      end else begin
        e = expected_q.pop_front();
        if (status !== e.status)
          report_mismatch($sformatf("status %0d, want %0d", status, e.status));
        if (slot_index !== e.slot)
          report_mismatch($sformatf("slot_index %0d, want %0d", slot_index, e.slot));
        if (cpu_handle !== e.cpu_h)
          report_mismatch($sformatf("cpu_handle %h, want %h", cpu_handle, e.cpu_h));
        if (gpu_handle !== e.gpu_h)
          report_mismatch($sformatf("gpu_handle %h, want %h", gpu_handle, e.gpu_h));
      end
    end
  end

  initial begin
    script_row_t row;
    int r;
    int idx;
    int other;
    logic [dsa_pkg::MODE_W-1:0] m;
    logic [dsa_pkg::ADDR_W-1:0] ca;
    logic [dsa_pkg::ADDR_W-1:0] ga;
    logic [dsa_pkg::ADDR_W-1:0] nb_cpu;
    logic [dsa_pkg::ADDR_W-1:0] nb_gpu;
    logic [dsa_pkg::INC_W-1:0] n_inc;
    logic [dsa_pkg::SLOT_COUNT_W-1:0] n_cnt;

    rst         = 1'b1;
    in_valid    = 1'b0;
    mode        = dsa_pkg::MODE_ALLOC;
    cpu_address = '0;
    gpu_address = '0;
    cfg_valid   = 1'b0;
    cfg_index   = dsa_pkg::CFG_CPU_BASE;
    cfg_data    = '0;
    base_cpu    = '0;
    base_gpu    = '0;
    stride      = dsa_pkg::INC_RESET;
    slots_cfg   = dsa_pkg::SLOT_COUNT_RESET;
    freed_depth = 0;
    fresh_idx   = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset config: bases 0, stride 32, 64 slots
    add_chk(dsa_pkg::MODE_ALLOC, '0, '0, dsa_pkg::ST_OK, 0, 64'd0, 64'd0);
    add_chk(dsa_pkg::MODE_ALLOC, '0, '0, dsa_pkg::ST_OK, 1, 64'd32, 64'd32);
    add_chk(dsa_pkg::MODE_FREE, 64'd32, 64'd32, dsa_pkg::ST_OK, 1, '0, '0);
    add_chk(dsa_pkg::MODE_ALLOC, '0, '0, dsa_pkg::ST_OK, 1, 64'd32, 64'd32);
    add_chk(dsa_pkg::MODE_FREE, 64'd0, 64'd32, dsa_pkg::ST_MISMATCH, 0, '0, '0);
    add_chk(dsa_pkg::MODE_FREE, 64'd2048, 64'd2048, dsa_pkg::ST_RANGE, 0, '0, '0);
    add_chk(dsa_pkg::MODE_FREE, '1, '1, dsa_pkg::ST_RANGE, 0, '0, '0);
    add_chk(dsa_pkg::MODE_FREE, 64'd0, 64'd31, dsa_pkg::ST_OK, 0, '0, '0);
    add_chk(dsa_pkg::MODE_FREE, 64'd63, 64'd32, dsa_pkg::ST_OK, 1, '0, '0);
    add_chk(dsa_pkg::MODE_FREE, 64'd0, 64'd0, dsa_pkg::ST_OVERFLOW, 0, '0, '0);
    add_chk(MODE_UNUSED, '1, '1, dsa_pkg::ST_OK, 0, '0, '0);
    add_chk(dsa_pkg::MODE_REINIT, '0, '0, dsa_pkg::ST_OK, 0, '0, '0);
    add_chk(dsa_pkg::MODE_FREE, 64'd0, 64'd0, dsa_pkg::ST_OVERFLOW, 0, '0, '0);
    // wrapping bases, widest stride, two slots
    add_write(dsa_pkg::CFG_CPU_BASE, 64'hFFFF_FFFF_FFFF_FFF0);
    add_write(dsa_pkg::CFG_GPU_BASE, 64'h8000_0000_0000_0000);
    add_write(dsa_pkg::CFG_INCREMENT, 64'hFFFF);
    add_write(dsa_pkg::CFG_SLOT_COUNT, 64'd2);
    add_chk(dsa_pkg::MODE_ALLOC, '0, '0, dsa_pkg::ST_OK, 0, 64'hFFFF_FFFF_FFFF_FFF0,
            64'h8000_0000_0000_0000);
    add_req(dsa_pkg::MODE_ALLOC, '0, '0);
    add_chk(dsa_pkg::MODE_ALLOC, '0, '0, dsa_pkg::ST_EMPTY, 0, '0, '0);
    add_req(dsa_pkg::MODE_FREE, 64'h0000_0000_0000_FFEF, 64'h8000_0000_0000_FFFF);
    add_req(dsa_pkg::MODE_FREE, 64'd0, 64'h8000_0000_0000_0000);
    // zero stride and zero slots: frees fail, stack still drains
    add_write(dsa_pkg::CFG_INCREMENT, 64'd0);
    add_write(dsa_pkg::CFG_SLOT_COUNT, 64'd0);
    add_chk(dsa_pkg::MODE_FREE, 64'd0, 64'd0, dsa_pkg::ST_RANGE, 0, '0, '0);
    add_req(dsa_pkg::MODE_ALLOC, '0, '0);
    add_req(dsa_pkg::MODE_ALLOC, '0, '0);
    add_chk(dsa_pkg::MODE_ALLOC, '0, '0, dsa_pkg::ST_EMPTY, 0, '0, '0);
    // slot count above pool depth
    add_write(dsa_pkg::CFG_CPU_BASE, 64'd0);
    add_write(dsa_pkg::CFG_GPU_BASE, 64'd0);
    add_write(dsa_pkg::CFG_INCREMENT, 64'd1);
    add_write(dsa_pkg::CFG_SLOT_COUNT, 64'd127);
    add_chk(dsa_pkg::MODE_REINIT, '0, '0, dsa_pkg::ST_OK, 0, '0, '0);
    add_chk(dsa_pkg::MODE_FREE, 64'd5, 64'd5, dsa_pkg::ST_OVERFLOW, 0, '0, '0);
    add_chk(dsa_pkg::MODE_ALLOC, '0, '0, dsa_pkg::ST_OK, 0, '0, '0);

    foreach (script[i]) begin
      row = script[i];
      if (row.is_write) begin
        drain();
        write_reg(row.sel, row.a);
      end else begin
        issue(row.req_mode, row.a, row.b, row.fixed, row.want);
        pause();
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      if (ph == 1) begin
        nb_cpu = '1;
        nb_gpu = '1;
        n_inc  = '1;
        n_cnt  = dsa_pkg::SLOT_COUNT_W'(dsa_pkg::MAX_SLOTS);
      end else if (ph == 2) begin
        nb_cpu = '0;
        nb_gpu = '0;
        n_inc  = dsa_pkg::INC_W'(1);
        n_cnt  = dsa_pkg::SLOT_COUNT_W'(1);
      end else begin
        nb_cpu = {$urandom, $urandom};
        nb_gpu = {$urandom, $urandom};
        r = $urandom_range(0, 99);
        n_inc = (r < 20) ? dsa_pkg::INC_W'(1) :
                (r < 40) ? '1 : dsa_pkg::INC_W'($urandom_range(1, 65535));
        r = $urandom_range(0, 99);
        n_cnt = (r < 30) ? dsa_pkg::SLOT_COUNT_W'(dsa_pkg::MAX_SLOTS) :
                (r < 50) ? dsa_pkg::SLOT_COUNT_W'($urandom_range(1, 3)) :
                (r < 60) ? dsa_pkg::SLOT_COUNT_W'(127) :
                dsa_pkg::SLOT_COUNT_W'($urandom_range(1, dsa_pkg::MAX_SLOTS));
      end
      write_reg(dsa_pkg::CFG_CPU_BASE, nb_cpu);
      write_reg(dsa_pkg::CFG_GPU_BASE, nb_gpu);
      write_reg(dsa_pkg::CFG_INCREMENT, dsa_pkg::ADDR_W'(n_inc));
      write_reg(dsa_pkg::CFG_SLOT_COUNT, dsa_pkg::ADDR_W'(n_cnt));
      calm = (ph == 3);
      if (ph == 5) hold_len = 300;

      for (int k = 0; k < PHASE_REQS; k++) begin
        r  = $urandom_range(0, 99);
        ca = {$urandom, $urandom};
        ga = {$urandom, $urandom};
        if (r < 35) begin
          m = dsa_pkg::MODE_ALLOC;
        end else if (r < 75) begin
          // free of a held slot, now and then a stray or repeated one
          m = dsa_pkg::MODE_FREE;
          if (live_slots.size() != 0 && $urandom_range(0, 9) != 0)
            idx = live_slots[$urandom_range(0, live_slots.size() - 1)];
          else
            idx = $urandom_range(0, dsa_pkg::MAX_SLOTS - 1);
          ca = base_cpu + dsa_pkg::ADDR_W'(idx) * dsa_pkg::ADDR_W'(stride) +
               dsa_pkg::ADDR_W'($urandom_range(0, stride - 1));
          ga = base_gpu + dsa_pkg::ADDR_W'(idx) * dsa_pkg::ADDR_W'(stride) +
               dsa_pkg::ADDR_W'($urandom_range(0, stride - 1));
        end else if (r < 85) begin
          m = dsa_pkg::MODE_FREE;
          idx = $urandom_range(0, dsa_pkg::MAX_SLOTS - 1);
          other = idx ^ $urandom_range(1, dsa_pkg::MAX_SLOTS - 1);
          ca = base_cpu + dsa_pkg::ADDR_W'(idx) * dsa_pkg::ADDR_W'(stride);
          ga = base_gpu + dsa_pkg::ADDR_W'(other) * dsa_pkg::ADDR_W'(stride);
        end else if (r < 94) begin
          m = dsa_pkg::MODE_FREE;
        end else if (r < 98) begin
          m = dsa_pkg::MODE_REINIT;
        end else begin
          m = MODE_UNUSED;
        end
        issue(m, ca, ga, 1'b0, '0);
        pause();
      end
      calm = 1'b0;
    end

    drain();
    repeat (40) @(posedge clk);
    if (err_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

[filelist.f]
src/dsa_pkg.sv
src/dsa_ctrl.sv
src/dsa_dpath.sv
src/descriptor_slot_allocator.sv
tb/descriptor_slot_allocator_tb.sv
